[hdl/lbp_pkg.sv]
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the lsb-first bit packer.
// ----------------------------------------------------------------------------
package lbp_pkg;

	localparam int unsigned DEF_MAX_FIELD_BITS = 24;
	localparam int unsigned CMD_DEPTH          = 2;
	localparam int unsigned MAX_RESULTS        = 5;

	// input command codes
	localparam logic [2:0] CMD_PUT_BITS = 3'd0;
	localparam logic [2:0] CMD_PUT_U8   = 3'd1;
	localparam logic [2:0] CMD_PUT_U16  = 3'd2;
	localparam logic [2:0] CMD_PUT_U24  = 3'd3;
	localparam logic [2:0] CMD_PUT_U32  = 3'd4;
	localparam logic [2:0] CMD_FLUSH    = 3'd5;

	typedef enum logic [1:0] {
		OP_BITS,
		OP_BYTES,
		OP_FLUSH,
		OP_ERROR
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] value;
		logic [4:0]  nbits;
		logic [2:0]  nbytes;
	} op_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       error_flag;
		logic       last;
	} result_t;

endpackage

[hdl/lbp_front.sv]
// ----------------------------------------------------------------------------
// lbp_front
// Accepts input items, classifies the command and latches the sticky error.
// ----------------------------------------------------------------------------
module lbp_front #(
	parameter int unsigned MAX_FIELD_BITS = lbp_pkg::DEF_MAX_FIELD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [2:0]        cmd,
	input  logic [31:0]       value,
	input  logic [4:0]        nbits,
	input  lbp_pkg::q_stat_t  q_stat,
	output logic              enq,
	output lbp_pkg::op_item_t item
);
	import lbp_pkg::*;

	logic sticky_q;
	logic take;
	logic keep;
	logic too_wide;

	assign take     = push && !q_stat.full;
	assign too_wide = {27'd0, nbits} > MAX_FIELD_BITS;

	always_comb begin
		keep        = 1'b1;
		item.value  = value;
		item.nbits  = nbits;
		item.nbytes = cmd;
		item.op     = OP_BITS;
		unique case (cmd)
			CMD_PUT_BITS: begin
				item.op = too_wide ? OP_ERROR : OP_BITS;
			end
			CMD_PUT_U8, CMD_PUT_U16, CMD_PUT_U24, CMD_PUT_U32: begin
				item.op = OP_BYTES;
			end
			CMD_FLUSH: begin
				item.op = OP_FLUSH;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// once the error is latched every transfer is swallowed here
	assign enq = take && keep && !sticky_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sticky_q <= 1'b0;
		end else if (enq && item.op == OP_ERROR) begin
			sticky_q <= 1'b1;
		end
	end

endmodule

[hdl/lbp_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// lbp_cmd_fifo
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module lbp_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              enq,
	input  lbp_pkg::op_item_t enq_item,
	input  logic              deq,
	output lbp_pkg::op_item_t deq_item,
	output lbp_pkg::q_stat_t  stat
);
	import lbp_pkg::*;

	localparam int unsigned PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMD_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMD_DEPTH);

	op_item_t         slot_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == FULL_CNT);
	assign deq_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_ptr_q] <= enq_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (deq && !enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full && !deq |-> !enq)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> !stat.empty)
		else $error("command queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("command queue count out of range");

endmodule

[hdl/lbp_back.sv]
// ----------------------------------------------------------------------------
// lbp_back
// Holds pending bits and emits result bytes, one per cycle unless output is held.
// ----------------------------------------------------------------------------
module lbp_back #(
	parameter int unsigned MAX_FIELD_BITS = lbp_pkg::DEF_MAX_FIELD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lbp_pkg::q_stat_t  q_stat,
	input  lbp_pkg::op_item_t item,
	output logic              deq,
	input  logic              res_pop,
	output logic              res_valid,
	output lbp_pkg::result_t  res
);
	import lbp_pkg::*;

	localparam int unsigned ACC_W  = MAX_FIELD_BITS + 7;
	localparam int unsigned WORK_W = (ACC_W > 40) ? ACC_W : 40;

	logic [6:0]          pend_q;
	logic [2:0]          pcnt_q;
	logic [WORK_W-1:0]   work_q;
	logic [2:0]          remain_q;
	logic                err_q;
	logic                res_valid_q;
	result_t             res_q;

	logic [MAX_FIELD_BITS-1:0] field;
	logic [ACC_W-1:0]          acc;
	logic [ACC_W-1:0]          rem;
	logic [5:0]                total;
	logic [WORK_W-1:0]         load_work;
	logic [2:0]                load_cnt;
	logic                      load_err;
	logic [6:0]                pend_n;
	logic [2:0]                pcnt_n;
	logic                      out_ready;
	logic                      emit;

	assign field = item.value[MAX_FIELD_BITS-1:0]
		& ~({MAX_FIELD_BITS{1'b1}} << item.nbits);
	assign acc   = ACC_W'(pend_q) | (ACC_W'(field) << pcnt_q);
	assign total = {3'd0, pcnt_q} + {1'b0, item.nbits};
	assign rem   = acc >> {total[5:3], 3'b000};

	always_comb begin
		load_work = '0;
		load_cnt  = '0;
		load_err  = 1'b0;
		pend_n    = '0;
		pcnt_n    = '0;
		unique case (item.op)
			OP_BITS: begin
				load_work = WORK_W'(acc);
				load_cnt  = total[5:3];
				pend_n    = rem[6:0];
				pcnt_n    = total[2:0];
			end
			OP_BYTES: begin
				// partial byte goes out first, zero padded
				if (pcnt_q != '0) begin
					load_work = WORK_W'({item.value, 1'b0, pend_q});
					load_cnt  = item.nbytes + 3'd1;
				end else begin
					load_work = WORK_W'(item.value);
					load_cnt  = item.nbytes;
				end
			end
			OP_FLUSH: begin
				load_work = WORK_W'(pend_q);
				load_cnt  = (pcnt_q != '0) ? 3'd1 : 3'd0;
			end
			OP_ERROR: begin
				load_cnt = 3'd1;
				load_err = 1'b1;
				pend_n   = pend_q;
				pcnt_n   = pcnt_q;
			end
			default: begin
				load_cnt = '0;
			end
		endcase
	end

	assign out_ready = !res_valid_q || res_pop;
	assign emit      = (remain_q != '0) && out_ready;
	assign deq       = (remain_q == '0) && !q_stat.empty;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			pcnt_q      <= '0;
			remain_q    <= '0;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
				remain_q    <= remain_q - 3'd1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
			if (deq) begin
				remain_q <= load_cnt;
				err_q    <= load_err;
				pend_q   <= pend_n;
				pcnt_q   <= pcnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.data       <= work_q[7:0];
			res_q.has_byte   <= !err_q;
			res_q.error_flag <= err_q;
			res_q.last       <= (remain_q == 3'd1);
			work_q           <= work_q >> 8;
		end else if (deq) begin
			work_q <= load_work;
		end
	end

	a_remain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		remain_q <= 3'(MAX_RESULTS))
		else $error("result count out of range");

	a_bytes_align: assert property (@(posedge clk) disable iff (!arst_n)
		deq && item.op == OP_BYTES |=> pcnt_q == '0 && pend_q == '0)
		else $error("byte command left pending bits");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.error_flag |-> !res_q.has_byte && res_q.last)
		else $error("malformed error report");

endmodule

[hdl/lsb_first_bit_packer.sv]
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs bit fields lsb-first into a byte stream, queue style on both sides.
// ----------------------------------------------------------------------------
// An item passes the front combinationally and waits in a two-entry command
// queue; the back end loads it when idle and then delivers its results at
// one per cycle through a single output register, while that register is
// empty or being popped, so an item occupies the back end for its load and
// for each of its results. That single byte lane in the back end sets the
// sustained rate. An item that gives no result still has to be loaded. Once a
// field wider than MAX_FIELD_BITS is seen, one error report is delivered and
// every later item is accepted and dropped until reset.
module lsb_first_bit_packer #(
	parameter int unsigned MAX_FIELD_BITS = lbp_pkg::DEF_MAX_FIELD_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  cmd,
	input  logic [31:0] value,
	input  logic [4:0]  nbits,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        has_byte,
	output logic        error_flag,
	output logic        last
);
	import lbp_pkg::*;

	q_stat_t  q_stat;
	op_item_t enq_item;
	op_item_t deq_item;
	logic     enq;
	logic     deq;
	logic     res_valid;
	result_t  res;

	lbp_front #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd    (cmd),
		.value  (value),
		.nbits  (nbits),
		.q_stat (q_stat),
		.enq    (enq),
		.item   (enq_item)
	);

	lbp_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (enq),
		.enq_item (enq_item),
		.deq      (deq),
		.deq_item (deq_item),
		.stat     (q_stat)
	);

	lbp_back #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.item      (deq_item),
		.deq       (deq),
		.res_pop   (pop),
		.res_valid (res_valid),
		.res       (res)
	);

	assign full       = q_stat.full;
	assign empty      = !res_valid;
	assign out_byte   = res.data;
	assign has_byte   = res.has_byte;
	assign error_flag = res.error_flag;
	assign last       = res.last;

endmodule
